// ===== rtl/bmte_pkg.sv =====
package bmte_pkg;

    localparam int LOGICAL_ENTRIES_DEF = 65536;
    localparam int DEVICE_ENTRIES_DEF  = 65536;
    localparam int MAX_RUN_DEF         = 256;

    localparam logic [2:0] F_REMAP = 3'd0;
    localparam logic [2:0] F_COPY  = 3'd1;
    localparam logic [2:0] F_COND  = 3'd2;
    localparam logic [2:0] F_LOOK  = 3'd3;
    localparam logic [2:0] F_QUERY = 3'd4;
    localparam logic [2:0] F_UNMAP = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOR  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [1:0] K_VALID    = 2'd0;
    localparam logic [1:0] K_UNMAPPED = 2'd1;
    localparam logic [1:0] K_INVALID  = 2'd2;

    localparam logic [1:0] REG_TABLE  = 2'd0;
    localparam logic [1:0] REG_USER   = 2'd1;
    localparam logic [1:0] REG_DEVICE = 2'd2;
    localparam logic [1:0] REG_ZONE   = 2'd3;

    localparam logic [16:0] TABLE_RST  = 17'd65536;
    localparam logic [16:0] USER_RST   = 17'd65536;
    localparam logic [16:0] DEVICE_RST = 17'd65536;
    localparam logic [16:0] ZONE_RST   = 17'd4096;

    localparam logic [16:0] EXPECT_UNMAPPED = 17'h10000;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] user_block;
        logic [15:0] target_block;
        logic [15:0] source_block;
        logic [8:0]  length;
        logic [16:0] expected_backing;
        logic [15:0] zone_start_block;
        logic [15:0] chunk_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_backing;
        logic [1:0]  backing_kind;
        logic [8:0]  run_length;
        logic        invalid_flag;
        logic        user_found;
        logic [15:0] owner_block;
        logic        remapped;
    } t_out_item;

    typedef struct packed {
        logic [16:0] table_blocks;
        logic [16:0] user_blocks;
        logic [16:0] device_blocks;
        logic [16:0] zone_blocks;
    } t_cfg;

endpackage

// ===== rtl/bmte_if.sv =====
interface bmte_in_if;
    logic               valid;
    logic               ready;
    bmte_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bmte_out_if;
    logic                valid;
    logic                ready;
    bmte_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/block_map_table_engine.sv =====
// Channel  | Direction | Handshake     | Payload
// i_in     | in        | valid / ready | t_in_item, one operation per item
// o_out    | out       | valid / ready | t_out_item, one result per item
// APB      | in        | psel/penable  | four 17-bit registers at 0x0..0xC
//
// One item at a time. Remap and copy read then write each block (S_RD, S_WR), lookup
// does the same and adds S_FLAG for each mapped block, flag query reads the flag
// (S_QRY, S_QCHK) and then scans table entries with S_RD and S_WR, and zone unmap
// visits each entry of table_blocks the same way; each item also passes S_IDLE and
// S_FIN. The map reads are registered, hence the read-then-write sequence. After reset
// a clearing pass over max(LOGICAL_ENTRIES, DEVICE_ENTRIES) entries runs before the
// first item is taken. A stalled result is held in the output register and the next item is accepted meanwhile.
module block_map_table_engine #(
    parameter int LOGICAL_ENTRIES = bmte_pkg::LOGICAL_ENTRIES_DEF,
    parameter int DEVICE_ENTRIES  = bmte_pkg::DEVICE_ENTRIES_DEF,
    parameter int MAX_RUN         = bmte_pkg::MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmte_in_if.sink     i_in,
    bmte_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW   = $clog2(LOGICAL_ENTRIES);
    localparam int DW   = $clog2(DEVICE_ENTRIES);
    localparam int AW   = (LW > DW) ? LW : DW;
    localparam int CMPW = (AW + 2 > 18) ? AW + 2 : 18;
    localparam int CLRN = (LOGICAL_ENTRIES > DEVICE_ENTRIES) ? LOGICAL_ENTRIES
                                                             : DEVICE_ENTRIES;
    localparam int CLRW = $clog2(CLRN);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_WR, S_FLAG, S_QRY, S_QCHK, S_FIN
    } t_state;

    bmte_pkg::t_cfg cfg;

    bmte_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [DW:0] r_fwd   [LOGICAL_ENTRIES];
    logic [LW:0] r_rev   [DEVICE_ENTRIES];
    logic        r_flags [DEVICE_ENTRIES];
    logic [DW:0] r_fwd_q;
    logic [LW:0] r_rev_q;
    logic        r_flag_q;

    logic [LW-1:0] fwd_ra, fwd_wa;
    logic [DW:0]   fwd_wd;
    logic          fwd_we;
    logic [DW-1:0] rev_ra, rev_wa;
    logic [LW:0]   rev_wd;
    logic          rev_we;
    logic [DW-1:0] flag_ra, flag_wa;
    logic          flag_wd, flag_we;

    t_state              r_state;
    logic [2:0]          r_func;
    logic [15:0]         r_user, r_back, r_src, r_zone;
    logic [16:0]         r_expect;
    logic [CMPW-1:0]     r_blk, r_idx, r_limit, r_zend;
    logic [DW-1:0]       r_prev;
    logic [1:0]          r_kind;
    logic [CLRW-1:0]     r_clr;
    bmte_pkg::t_out_item r_res, r_odata;
    logic                r_ovalid;

    logic [CMPW-1:0] tb, ub, db;
    logic [CMPW-1:0] a_user, a_back, a_src;
    logic            cur_map, idx_last, match, zone_hit, scan_hit;
    logic [DW-1:0]   cur_dev;

    logic [1:0]          acc_st;
    t_state              acc_next;
    logic [CMPW-1:0]     acc_limit, acc_blk, acc_zend;

    logic [1:0]          lk_kind;
    logic                lk_cont, lk_stop;
    bmte_pkg::t_out_item n_res;

    always_comb begin
        tb = (CMPW'(cfg.table_blocks) < CMPW'(LOGICAL_ENTRIES))
             ? CMPW'(cfg.table_blocks) : CMPW'(LOGICAL_ENTRIES);
        ub = (CMPW'(cfg.user_blocks) < CMPW'(LOGICAL_ENTRIES))
             ? CMPW'(cfg.user_blocks) : CMPW'(LOGICAL_ENTRIES);
        db = (CMPW'(cfg.device_blocks) < CMPW'(DEVICE_ENTRIES))
             ? CMPW'(cfg.device_blocks) : CMPW'(DEVICE_ENTRIES);
    end

    always_comb begin
        logic [CMPW-1:0] lenx, ux, bx, sx;
        lenx      = CMPW'(i_in.data.length);
        ux        = CMPW'(i_in.data.user_block);
        bx        = CMPW'(i_in.data.target_block);
        sx        = CMPW'(i_in.data.source_block);
        acc_blk   = CMPW'(i_in.data.zone_start_block) + CMPW'(i_in.data.chunk_offset);
        acc_zend  = CMPW'(i_in.data.zone_start_block) + CMPW'(cfg.zone_blocks);
        acc_st    = bmte_pkg::ST_OK;
        acc_next  = S_FIN;
        acc_limit = lenx;
        case (i_in.data.func)
            bmte_pkg::F_REMAP, bmte_pkg::F_COPY, bmte_pkg::F_LOOK: begin
                if (lenx == '0) begin
                    acc_st = bmte_pkg::ST_ZERO;
                end else if (lenx > CMPW'(MAX_RUN)) begin
                    acc_st = bmte_pkg::ST_OOR;
                end else if (i_in.data.func == bmte_pkg::F_REMAP) begin
                    if (ux + lenx > tb || bx + lenx > db) acc_st = bmte_pkg::ST_OOR;
                    else acc_next = S_RD;
                end else if (i_in.data.func == bmte_pkg::F_COPY) begin
                    if (sx + lenx > db || bx + lenx > db) acc_st = bmte_pkg::ST_OOR;
                    else acc_next = S_RD;
                end else begin
                    if (ux + lenx > ub) acc_st = bmte_pkg::ST_OOR;
                    else acc_next = S_RD;
                end
            end
            bmte_pkg::F_COND: begin
                acc_limit = CMPW'(1);
                if (ux >= ub || bx >= db) acc_st = bmte_pkg::ST_OOR;
                else acc_next = S_RD;
            end
            bmte_pkg::F_QUERY: begin
                acc_limit = tb;
                if (acc_blk >= db) acc_st = bmte_pkg::ST_OOR;
                else acc_next = S_QRY;
            end
            bmte_pkg::F_UNMAP: begin
                acc_limit = tb;
                if (CMPW'(i_in.data.zone_start_block) >= db) acc_st = bmte_pkg::ST_OOR;
                else if (tb != '0) acc_next = S_RD;
            end
            default: acc_st = bmte_pkg::ST_OOR;
        endcase
    end

    always_comb begin
        a_user   = CMPW'(r_user) + r_idx;
        a_back   = CMPW'(r_back) + r_idx;
        a_src    = CMPW'(r_src) + r_idx;
        cur_map  = !r_fwd_q[DW];
        cur_dev  = r_fwd_q[DW-1:0];
        idx_last = (r_idx + CMPW'(1) == r_limit);
        if (cur_map) begin
            match = (r_expect < bmte_pkg::EXPECT_UNMAPPED)
                    && (CMPW'(r_expect) == CMPW'(cur_dev));
        end else begin
            match = (r_expect == bmte_pkg::EXPECT_UNMAPPED);
        end
        zone_hit = cur_map && CMPW'(cur_dev) >= CMPW'(r_zone) && CMPW'(cur_dev) < r_zend;
        scan_hit = cur_map && CMPW'(cur_dev) == r_blk;
    end

    always_comb begin
        if (!cur_map) lk_kind = bmte_pkg::K_UNMAPPED;
        else if (r_flag_q) lk_kind = bmte_pkg::K_INVALID;
        else lk_kind = bmte_pkg::K_VALID;
        lk_cont = (lk_kind == r_kind)
                  && (lk_kind != bmte_pkg::K_VALID
                      || CMPW'(cur_dev) == CMPW'(r_prev) + CMPW'(1));
        n_res = r_res;
        if (r_idx == '0) begin
            n_res.found_backing = cur_map ? 16'(cur_dev) : 16'd0;
            n_res.backing_kind  = lk_kind;
            n_res.run_length    = 9'd1;
            lk_stop             = idx_last;
        end else if (lk_cont) begin
            n_res.run_length = r_res.run_length + 9'd1;
            lk_stop          = idx_last;
        end else begin
            lk_stop = 1'b1;
        end
    end

    always_comb begin
        fwd_ra  = (r_func == bmte_pkg::F_QUERY || r_func == bmte_pkg::F_UNMAP)
                  ? r_idx[LW-1:0] : a_user[LW-1:0];
        rev_ra  = a_src[DW-1:0];
        flag_ra = (r_state == S_QRY) ? r_blk[DW-1:0] : cur_dev;
        fwd_we  = 1'b0;
        fwd_wa  = a_user[LW-1:0];
        fwd_wd  = {1'b0, a_back[DW-1:0]};
        rev_we  = 1'b0;
        rev_wa  = a_back[DW-1:0];
        rev_wd  = {1'b0, a_user[LW-1:0]};
        flag_we = 1'b0;
        flag_wa = cur_dev;
        flag_wd = 1'b1;
        if (r_state == S_CLEAR) begin
            fwd_we  = (CLRW+1)'(r_clr) < (CLRW+1)'(LOGICAL_ENTRIES);
            fwd_wa  = r_clr[LW-1:0];
            fwd_wd  = {1'b1, {DW{1'b0}}};
            rev_we  = (CLRW+1)'(r_clr) < (CLRW+1)'(DEVICE_ENTRIES);
            rev_wa  = r_clr[DW-1:0];
            rev_wd  = {1'b1, {LW{1'b0}}};
            flag_we = rev_we;
            flag_wa = r_clr[DW-1:0];
            flag_wd = 1'b0;
        end else if (r_state == S_WR) begin
            case (r_func)
                bmte_pkg::F_REMAP: begin
                    flag_we = cur_map;
                    fwd_we  = 1'b1;
                    rev_we  = 1'b1;
                end
                bmte_pkg::F_COND: begin
                    flag_we = match && cur_map;
                    fwd_we  = match;
                    rev_we  = match;
                end
                bmte_pkg::F_COPY: begin
                    fwd_we = !r_rev_q[LW];
                    fwd_wa = r_rev_q[LW-1:0];
                    rev_we = !r_rev_q[LW];
                    rev_wd = r_rev_q;
                end
                bmte_pkg::F_UNMAP: begin
                    fwd_we = zone_hit;
                    fwd_wa = r_idx[LW-1:0];
                    fwd_wd = {1'b1, {DW{1'b0}}};
                    rev_we = zone_hit;
                    rev_wa = cur_dev;
                    rev_wd = {1'b1, {LW{1'b0}}};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) r_fwd[fwd_wa] <= fwd_wd;
        if (rev_we) r_rev[rev_wa] <= rev_wd;
        if (flag_we) r_flags[flag_wa] <= flag_wd;
        r_fwd_q  <= r_fwd[fwd_ra];
        r_rev_q  <= r_rev[rev_ra];
        r_flag_q <= r_flags[flag_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && r_state != S_FIN) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLRW'(1);
                    if (r_clr == CLRW'(CLRN - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func   <= i_in.data.func;
                        r_user   <= i_in.data.user_block;
                        r_back   <= i_in.data.target_block;
                        r_src    <= i_in.data.source_block;
                        r_expect <= i_in.data.expected_backing;
                        r_zone   <= i_in.data.zone_start_block;
                        r_blk    <= acc_blk;
                        r_zend   <= acc_zend;
                        r_limit  <= acc_limit;
                        r_idx    <= '0;
                        r_res    <= '{status: acc_st, default: '0};
                        r_state  <= acc_next;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    case (r_func)
                        bmte_pkg::F_COND: begin
                            r_res.remapped <= match;
                            r_state        <= S_FIN;
                        end
                        bmte_pkg::F_LOOK: begin
                            if (cur_map) begin
                                r_state <= S_FLAG;
                            end else begin
                                r_res   <= n_res;
                                r_prev  <= cur_dev;
                                r_kind  <= (r_idx == '0) ? lk_kind : r_kind;
                                r_idx   <= r_idx + CMPW'(1);
                                r_state <= lk_stop ? S_FIN : S_RD;
                            end
                        end
                        bmte_pkg::F_QUERY: begin
                            if (scan_hit) begin
                                {r_res.user_found, r_res.owner_block} <=
                                    {1'b1, r_idx[15:0]};
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= r_idx + CMPW'(1);
                                r_state <= idx_last ? S_FIN : S_RD;
                            end
                        end
                        default: begin
                            r_idx   <= r_idx + CMPW'(1);
                            r_state <= idx_last ? S_FIN : S_RD;
                        end
                    endcase
                end
                S_FLAG: begin
                    r_res   <= n_res;
                    r_prev  <= cur_dev;
                    r_kind  <= (r_idx == '0) ? lk_kind : r_kind;
                    r_idx   <= r_idx + CMPW'(1);
                    r_state <= lk_stop ? S_FIN : S_RD;
                end
                S_QRY: r_state <= S_QCHK;
                S_QCHK: begin
                    if (r_flag_q) begin
                        r_res.invalid_flag <= 1'b1;
                        r_state            <= S_FIN;
                    end else if (r_limit == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_odata  <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

endmodule

// ===== rtl/bmte_regs.sv =====
module bmte_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bmte_pkg::t_cfg      o_cfg
);

    bmte_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_blocks  <= bmte_pkg::TABLE_RST;
            r_cfg.user_blocks   <= bmte_pkg::USER_RST;
            r_cfg.device_blocks <= bmte_pkg::DEVICE_RST;
            r_cfg.zone_blocks   <= bmte_pkg::ZONE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                bmte_pkg::REG_TABLE:  r_cfg.table_blocks  <= pwdata[16:0];
                bmte_pkg::REG_USER:   r_cfg.user_blocks   <= pwdata[16:0];
                bmte_pkg::REG_DEVICE: r_cfg.device_blocks <= pwdata[16:0];
                default:              r_cfg.zone_blocks   <= pwdata[16:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bmte_pkg::REG_TABLE:  prdata = 32'(r_cfg.table_blocks);
            bmte_pkg::REG_USER:   prdata = 32'(r_cfg.user_blocks);
            bmte_pkg::REG_DEVICE: prdata = 32'(r_cfg.device_blocks);
            default:              prdata = 32'(r_cfg.zone_blocks);
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ===== rtl/bmte_checker.sv =====
module bmte_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input bmte_pkg::t_out_item i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is at work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("activity straight after reset");

endmodule

bind block_map_table_engine bmte_checker u_bmte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== sim/tb_block_map_table_engine.sv =====
`timescale 1ns / 1ps

module tb_block_map_table_engine;

    localparam int unsigned UNMAPPED = 32'hFFFF_FFFF;
    localparam int unsigned NBLK     = 65536;

    class map_scoreboard;
        int unsigned         fwd_map[NBLK];
        int unsigned         rev_map[NBLK];
        bit                  bad_blk[NBLK];
        int unsigned         tbl_lim, usr_lim, dev_lim, zone_len;
        bmte_pkg::t_out_item pending[$];
        int                  errors;

        function new();
            for (int i = 0; i < NBLK; i++) begin
                fwd_map[i] = UNMAPPED;
                rev_map[i] = UNMAPPED;
                bad_blk[i] = 1'b0;
            end
            tbl_lim  = 32'(bmte_pkg::TABLE_RST);
            usr_lim  = 32'(bmte_pkg::USER_RST);
            dev_lim  = 32'(bmte_pkg::DEVICE_RST);
            zone_len = 32'(bmte_pkg::ZONE_RST);
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                bmte_pkg::REG_TABLE:  tbl_lim  = val;
                bmte_pkg::REG_USER:   usr_lim  = val;
                bmte_pkg::REG_DEVICE: dev_lim  = val;
                default:              zone_len = val;
            endcase
        endfunction

        function logic [1:0] kind_at(int unsigned dev);
            if (dev == UNMAPPED) return bmte_pkg::K_UNMAPPED;
            return (dev < NBLK && bad_blk[dev]) ? bmte_pkg::K_INVALID : bmte_pkg::K_VALID;
        endfunction

        function void link(int unsigned u, int unsigned d);
            if (u < NBLK && d < NBLK) begin
                fwd_map[u] = d;
                rev_map[d] = u;
            end
        endfunction

        function void retire(int unsigned u);
            if (u < NBLK && fwd_map[u] < NBLK) bad_blk[fwd_map[u]] = 1'b1;
        endfunction

        function void note_item(bmte_pkg::t_in_item it);
            bmte_pkg::t_out_item r;
            int unsigned usr, bk, src, len, exp_bk, cur, run, blk, zone, zend;
            bit          hit;
            r      = '0;
            usr    = 32'(it.user_block);
            bk     = 32'(it.target_block);
            src    = 32'(it.source_block);
            len    = 32'(it.length);
            exp_bk = 32'(it.expected_backing);
            zone   = 32'(it.zone_start_block);
            if ((it.func == bmte_pkg::F_REMAP || it.func == bmte_pkg::F_COPY ||
                 it.func == bmte_pkg::F_LOOK) &&
                (len == 0 || len > bmte_pkg::MAX_RUN_DEF)) begin
                r.status = (len == 0) ? bmte_pkg::ST_ZERO : bmte_pkg::ST_OOR;
            end else begin
                case (it.func)
                    bmte_pkg::F_REMAP: begin
                        if (usr + len > tbl_lim || bk + len > dev_lim) begin
                            r.status = bmte_pkg::ST_OOR;
                        end else begin
                            for (int i = 0; i < len; i++) begin
                                if (fwd_map[usr + i] != UNMAPPED) retire(usr + i);
                                link(usr + i, bk + i);
                            end
                        end
                    end
                    bmte_pkg::F_COPY: begin
                        if (src + len > dev_lim || bk + len > dev_lim) begin
                            r.status = bmte_pkg::ST_OOR;
                        end else begin
                            for (int i = 0; i < len; i++)
                                if (rev_map[src + i] != UNMAPPED)
                                    link(rev_map[src + i], bk + i);
                        end
                    end
                    bmte_pkg::F_COND: begin
                        if (usr >= usr_lim || bk >= dev_lim) begin
                            r.status = bmte_pkg::ST_OOR;
                        end else begin
                            cur = fwd_map[usr];
                            hit = (cur == UNMAPPED)
                                  ? (exp_bk == 32'(bmte_pkg::EXPECT_UNMAPPED))
                                  : (exp_bk < NBLK && exp_bk == cur);
                            if (hit) begin
                                if (cur != UNMAPPED) retire(usr);
                                link(usr, bk);
                                r.remapped = 1'b1;
                            end
                        end
                    end
                    bmte_pkg::F_LOOK: begin
                        if (usr + len > usr_lim) begin
                            r.status = bmte_pkg::ST_OOR;
                        end else begin
                            cur = fwd_map[usr];
                            r.backing_kind = kind_at(cur);
                            run = 1;
                            while (run < len) begin
                                if (kind_at(fwd_map[usr + run]) != r.backing_kind) break;
                                if (r.backing_kind == bmte_pkg::K_VALID &&
                                    fwd_map[usr + run] != fwd_map[usr + run - 1] + 1) break;
                                run++;
                            end
                            r.found_backing = (cur == UNMAPPED) ? 16'd0 : cur[15:0];
                            r.run_length    = run[8:0];
                        end
                    end
                    bmte_pkg::F_QUERY: begin
                        blk = zone + 32'(it.chunk_offset);
                        if (blk >= dev_lim) begin
                            r.status = bmte_pkg::ST_OOR;
                        end else begin
                            r.invalid_flag = bad_blk[blk];
                            if (!bad_blk[blk]) begin
                                for (int i = 0; i < tbl_lim; i++) begin
                                    if (fwd_map[i] == blk) begin
                                        r.user_found  = 1'b1;
                                        r.owner_block = i[15:0];
                                        break;
                                    end
                                end
                            end
                        end
                    end
                    bmte_pkg::F_UNMAP: begin
                        zend = zone + zone_len;
                        if (zone >= dev_lim) begin
                            r.status = bmte_pkg::ST_OOR;
                        end else begin
                            for (int i = 0; i < tbl_lim; i++) begin
                                cur = fwd_map[i];
                                if (cur != UNMAPPED && cur >= zone && cur < zend) begin
                                    if (cur < NBLK) rev_map[cur] = UNMAPPED;
                                    fwd_map[i] = UNMAPPED;
                                end
                            end
                        end
                    end
                    default: r.status = bmte_pkg::ST_OOR;
                endcase
            end
            pending.push_back(r);
        endfunction

        function void cmp_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(bmte_pkg::t_out_item a);
            bmte_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp_field("status", 32'(e.status), 32'(a.status));
            cmp_field("found_backing", 32'(e.found_backing), 32'(a.found_backing));
            cmp_field("backing_kind", 32'(e.backing_kind), 32'(a.backing_kind));
            cmp_field("run_length", 32'(e.run_length), 32'(a.run_length));
            cmp_field("invalid_flag", 32'(e.invalid_flag), 32'(a.invalid_flag));
            cmp_field("user_found", 32'(e.user_found), 32'(a.user_found));
            cmp_field("owner_block", 32'(e.owner_block), 32'(a.owner_block));
            cmp_field("remapped", 32'(e.remapped), 32'(a.remapped));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          idle_mode;

    bmte_in_if  in_if ();
    bmte_out_if out_if ();

    map_scoreboard sb;

    block_map_table_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        case (idle_mode)
            0:       out_if.ready = ($urandom_range(0, 99) >= 82);
            1:       out_if.ready = ($urandom_range(0, 99) >= 13);
            default: out_if.ready = 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_item(bmte_pkg::t_in_item it);
        @(negedge i_clk);
        while (idle_mode == 0 && $urandom_range(0, 99) < 13) @(negedge i_clk);
        while (idle_mode == 1 && $urandom_range(0, 99) < 82) @(negedge i_clk);
        in_if.valid = 1'b1;
        in_if.data  = it;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(it);
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic send_op(logic [2:0] f, int unsigned usr, int unsigned bk, int unsigned src,
                           int unsigned len, int unsigned exp_bk, int unsigned zone,
                           int unsigned chunk);
        bmte_pkg::t_in_item it;
        it.func             = f;
        it.user_block       = 16'(usr);
        it.target_block     = 16'(bk);
        it.source_block     = 16'(src);
        it.length           = 9'(len);
        it.expected_backing = 17'(exp_bk);
        it.zone_start_block = 16'(zone);
        it.chunk_offset     = 16'(chunk);
        send_item(it);
    endtask

    task automatic settle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int unsigned pick(int unsigned lim);
        return (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    endfunction

    task automatic send_random();
        bmte_pkg::t_in_item it;
        logic [127:0]       raw;
        int unsigned        lim_u, lim_d, len;
        raw   = {$urandom, $urandom, $urandom, $urandom};
        it    = raw[$bits(bmte_pkg::t_in_item)-1:0];
        lim_u = (sb.usr_lim < sb.tbl_lim) ? sb.usr_lim : sb.tbl_lim;
        lim_d = sb.dev_lim;
        if ($urandom_range(0, 99) < 85) begin
            it.func = 3'($urandom_range(0, 5));
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(0, 511);
                1:       len = $urandom_range(1, 256);
                default: len = $urandom_range(1, 12);
            endcase
            it.length           = 9'(len);
            it.user_block       = (it.func == bmte_pkg::F_COND || it.func == bmte_pkg::F_LOOK)
                                  ? 16'(pick(sb.usr_lim)) : 16'(pick(lim_u));
            it.target_block     = 16'(pick(lim_d));
            it.source_block     = 16'(pick(lim_d));
            it.zone_start_block = 16'(pick(lim_d));
            it.chunk_offset     = 16'(pick(lim_d - 32'(it.zone_start_block)));
            if ($urandom_range(0, 99) < 60)
                it.expected_backing = (sb.fwd_map[it.user_block] == UNMAPPED) ?
                                      bmte_pkg::EXPECT_UNMAPPED
                                      : 17'(sb.fwd_map[it.user_block]);
        end
        send_item(it);
    endtask

    task automatic run_phase(int unsigned tbl, int unsigned usr, int unsigned dev,
                             int unsigned zone, int count, int mode);
        settle();
        write_reg(bmte_pkg::REG_TABLE, tbl);
        write_reg(bmte_pkg::REG_USER, usr);
        write_reg(bmte_pkg::REG_DEVICE, dev);
        write_reg(bmte_pkg::REG_ZONE, zone);
        idle_mode = mode;
        for (int i = 0; i < count; i++) send_random();
    endtask

    initial begin
        sb          = new();
        idle_mode   = 0;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_op(bmte_pkg::F_LOOK, 0, 0, 0, 1, 0, 0, 0);
        send_op(bmte_pkg::F_REMAP, 0, 0, 0, 256, 0, 0, 0);
        send_op(bmte_pkg::F_LOOK, 0, 0, 0, 256, 0, 0, 0);
        send_op(bmte_pkg::F_REMAP, 10, 1000, 0, 5, 0, 0, 0);
        send_op(bmte_pkg::F_LOOK, 8, 0, 0, 10, 0, 0, 0);
        send_op(bmte_pkg::F_LOOK, 11, 0, 0, 3, 0, 0, 0);
        send_op(bmte_pkg::F_QUERY, 0, 0, 0, 0, 0, 10, 2);
        send_op(bmte_pkg::F_QUERY, 0, 0, 0, 0, 0, 1000, 0);
        send_op(bmte_pkg::F_COND, 10, 2000, 0, 0, 1000, 0, 0);
        send_op(bmte_pkg::F_COND, 10, 2001, 0, 0, 1000, 0, 0);
        send_op(bmte_pkg::F_COND, 65535, 65535, 0, 0, 32'(bmte_pkg::EXPECT_UNMAPPED), 0, 0);
        send_op(bmte_pkg::F_COND, 11, 3, 0, 0, 32'h1FFFF, 0, 0);
        send_op(bmte_pkg::F_COPY, 0, 3000, 0, 4, 0, 0, 0);
        send_op(bmte_pkg::F_COPY, 0, 65535, 65535, 1, 0, 0, 0);
        send_op(bmte_pkg::F_REMAP, 0, 0, 0, 0, 0, 0, 0);
        send_op(bmte_pkg::F_LOOK, 0, 0, 0, 257, 0, 0, 0);
        send_op(bmte_pkg::F_COPY, 0, 0, 0, 511, 0, 0, 0);
        send_op(bmte_pkg::F_REMAP, 65535, 0, 0, 2, 0, 0, 0);
        send_op(bmte_pkg::F_LOOK, 65280, 0, 0, 256, 0, 0, 0);
        send_op(bmte_pkg::F_QUERY, 0, 0, 0, 0, 0, 65535, 65535);
        send_op(bmte_pkg::F_UNMAP, 0, 0, 0, 0, 0, 0, 0);
        send_op(bmte_pkg::F_LOOK, 0, 0, 0, 20, 0, 0, 0);
        send_op(3'd6, 0, 0, 0, 1, 0, 0, 0);
        send_op(3'd7, 65535, 65535, 65535, 511, 32'h1FFFF, 65535, 65535);

        run_phase(64, 64, 64, 8, 300, 0);
        run_phase(1, 1, 1, 1, 60, 0);
        run_phase(200, 128, 300, 65536, 300, 1);
        run_phase(48, 65536, 65536, 16, 300, 1);
        settle();
        idle_mode = 0;
        send_op(bmte_pkg::F_UNMAP, 0, 0, 0, 0, 0, 65535, 0);
        send_op(bmte_pkg::F_QUERY, 0, 0, 0, 0, 0, 65535, 0);
        run_phase(128, 96, 40000, 4096, 300, 2);
        run_phase(32, 40, 65536, 65536, 300, 2);
        settle();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
